@@ sv/rtcm3d_pkg.sv @@
// Shared types and constants for the RTCM3 frame deframer.
// No dependencies; every other file of the block imports this package.
package rtcm3d_pkg;

    localparam logic [7:0] PREAMBLE      = 8'hD3;
    localparam int         LEN_W         = 11;
    localparam logic [LEN_W-1:0] PARITY_BYTES = 11'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PHASE_HUNT   = 2'd0,
        PHASE_LENGTH = 2'd1,
        PHASE_BODY   = 2'd2
    } phase_t;

    // One job for the output side: a single byte, or the preamble followed by
    // the header byte held in data.
    typedef struct packed {
        logic       pair;
        logic [7:0] data;
        logic       last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ sv/rtcm3d_front.sv @@
// Front end of the deframer: preamble hunt, length capture and body count.
// Depends on rtcm3d_pkg; feeds jobs into rtcm3d_queue.
module rtcm3d_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               rx_byte,
    input  rtcm3d_pkg::queue_status_t q_status,
    output logic                     push,
    output rtcm3d_pkg::job_t         push_job
);
    import rtcm3d_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [7:0]        prev_reg, prev_next;
    logic [1:0]        len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;

    logic              accept;
    logic              sync;
    logic [LEN_W-1:0]  remain_dec;
    logic              body_last;

    assign in_stall   = q_status.full;
    assign accept     = in_valid && !q_status.full;
    assign sync       = (prev_reg == PREAMBLE) && (rx_byte[7:2] == 6'd0);
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
    assign body_last  = (remain_dec == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PHASE_LENGTH: phase_next = PHASE_BODY;
                PHASE_BODY:   phase_next = body_last ? PHASE_HUNT : PHASE_BODY;
                default:      phase_next = sync ? PHASE_LENGTH : PHASE_HUNT;
            endcase
        end
    end

    always_comb
    begin
        push          = 1'b0;
        push_job.pair = 1'b0;
        push_job.data = rx_byte;
        push_job.last = 1'b0;
        prev_next     = prev_reg;
        len_hi_next   = len_hi_reg;
        remain_next   = remain_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PHASE_LENGTH:
                begin
                    push        = 1'b1;
                    remain_next = {1'b0, len_hi_reg, rx_byte} + PARITY_BYTES;
                end
                PHASE_BODY:
                begin
                    push          = 1'b1;
                    push_job.last = body_last;
                    remain_next   = remain_dec;
                    if (body_last)
                    begin
                        prev_next = 8'd0;
                    end
                end
                default:
                begin
                    // The unused phase code behaves as hunting.
                    if (sync)
                    begin
                        push          = 1'b1;
                        push_job.pair = 1'b1;
                        len_hi_next   = rx_byte[1:0];
                    end
                    else
                    begin
                        prev_next = rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_HUNT;
            prev_reg   <= 8'd0;
            len_hi_reg <= 2'd0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ sv/rtcm3d_queue.sv @@
// Short job queue between the front end and the output side.
// Depends on rtcm3d_pkg.
module rtcm3d_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  rtcm3d_pkg::job_t          push_job,
    input  logic                      pop,
    output rtcm3d_pkg::job_t          head_job,
    output rtcm3d_pkg::queue_status_t q_status
);
    import rtcm3d_pkg::*;

    job_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                    do_push, do_pop;

    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/rtcm3d_back.sv @@
// Output side of the deframer: expands queued jobs into output bytes.
// Depends on rtcm3d_pkg; drains rtcm3d_queue.
module rtcm3d_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rtcm3d_pkg::job_t          head_job,
    input  rtcm3d_pkg::queue_status_t q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                frame_byte,
    output logic                      frame_end
);
    import rtcm3d_pkg::*;

    logic        valid_reg, valid_next;
    logic        half_reg, half_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic        load;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        half_next  = half_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        if (load)
        begin
            valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                // A sync job emits the preamble first and stays at the head until
                // its header byte has also been loaded into the output register.
                if (head_job.pair && !half_reg)
                begin
                    byte_next = PREAMBLE;
                    end_next  = 1'b0;
                    half_next = 1'b1;
                end
                else
                begin
                    byte_next = head_job.data;
                    end_next  = head_job.last;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    assign out_valid  = valid_reg;
    assign frame_byte = byte_reg;
    assign frame_end  = end_reg;

endmodule

@@ sv/rtcm3_frame_deframer.sv @@
// RTCM3 frame deframer: hunts a byte stream for the 0xD3 preamble followed by
// a header byte with its top six bits clear, then passes the whole frame out
// (preamble, header, length byte, payload and three parity bytes), with
// frame_end on the last parity byte; bytes outside a frame are dropped and the
// CRC is not checked. One byte is taken per cycle while the job queue is not
// full; the bytes of a frame pass through the job queue into the output
// register. The output register moves one byte per cycle while out_stall is
// low, so the sync byte, which yields two output bytes, is absorbed by the
// four-entry job queue between the front end and the output side; the input
// stalls only when that queue is full, which happens only after the output has stalled.
// Depends on rtcm3d_pkg, rtcm3d_front, rtcm3d_queue and rtcm3d_back.
module rtcm3_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_end
);
    import rtcm3d_pkg::*;

    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head_job;
    queue_status_t q_status;

    rtcm3d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    rtcm3d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    rtcm3d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end)
    );

endmodule

@@ sv/rtcm3d_checker.sv @@
// Port-level checks for the RTCM3 frame deframer, bound to the top level.
// Depends on rtcm3d_pkg and rtcm3_frame_deframer.
module rtcm3d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       frame_end
);
    import rtcm3d_pkg::*;

    logic in_xfer, out_xfer;
    logic seen_input_reg;
    logic expect_pre_reg;
    logic expect_hdr_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_input_reg <= 1'b0;
            expect_pre_reg <= 1'b1;
            expect_hdr_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                seen_input_reg <= 1'b1;
            end
            if (out_xfer)
            begin
                expect_pre_reg <= frame_end;
                expect_hdr_reg <= expect_pre_reg;
            end
        end
    end

    // A result held back by the receiver does not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(frame_end))
        else $error("output changed while stalled");

    // Nothing comes out before any byte has gone in.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_input_reg)
        else $error("output before any input transfer");

    // Every frame opens with the preamble.
    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && expect_pre_reg |-> frame_byte == PREAMBLE && !frame_end)
        else $error("frame does not start with the preamble");

    // The byte after the preamble is a valid header byte.
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && expect_hdr_reg |-> frame_byte[7:2] == 6'd0 && !frame_end)
        else $error("bad header byte after preamble");

endmodule

bind rtcm3_frame_deframer rtcm3d_checker u_rtcm3d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
);
